### rtl/ksel_pkg.sv
// Shared types and codes for the k-smallest selector.
`default_nettype none
package ksel_pkg;

  localparam int unsigned SEL_BITS = 7;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_FEW  = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_ERR   = 3'b100
  } ksel_state_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } ksel_cell_ctl_t;

endpackage
`default_nettype wire

### rtl/ksel_cell.sv
// One cell of the sorted chain: holds one value, inserts or shifts toward the head.
`default_nettype none
module ksel_cell import ksel_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire ksel_cell_ctl_t          ctl,
  input  wire                          occupied,
  input  wire logic signed [VALUE_BITS-1:0] new_value,
  input  wire logic signed [VALUE_BITS-1:0] prev_value,
  input  wire                          prev_le,
  input  wire logic signed [VALUE_BITS-1:0] next_value,
  output logic signed [VALUE_BITS-1:0] value,
  output logic                         le
);

  logic signed [VALUE_BITS-1:0] value_r;

  // Kept value stays ahead of the new one when it is not larger (stable order)
  assign le    = occupied && (value_r <= new_value);
  assign value = value_r;

  // Insert: cells behind the slot move back by one, the slot takes the new value.
  // Shift: every cell takes its successor's value.
  always_ff @(posedge clk) begin
    if (ctl.insert && !le) begin
      value_r <= prev_le ? new_value : prev_value;
    end else if (ctl.shift) begin
      value_r <= next_value;
    end
  end

endmodule
`default_nettype wire

### rtl/k_smallest_selector_core.sv
// Top level of the k-smallest selector: sorted cell chain, sequencer and output register.
//
//  channel | ports                                         | role
//  --------+-----------------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_sample_value, in_set_end | set elements
//  out     | out_valid, out_ready, out_picked_value,         | k smallest, ascending
//          | out_run_end, out_status                       |
//  cfg     | cfg_we, cfg_wdata                             | select count, no wait
//
// Elements load at one per cycle: each transaction is compared against all cells at once
// and inserted in the same cycle. After a set_end element with a nonzero select count,
// in_ready drops while the chain shifts its head into the output register, one result
// per cycle when out_ready is high: k results or one error result, then in_ready returns.
// Reset (rst_n, synchronous) empties the chain and sets the select count to one.
// Stalls on out_ready freeze the chain; the last result may wait while loading resumes.
`default_nettype none
module k_smallest_selector_core import ksel_pkg::*; #(
  parameter int unsigned MAX_SELECT = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire logic signed [VALUE_BITS-1:0] in_sample_value,
  input  wire                          in_set_end,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [VALUE_BITS-1:0] out_picked_value,
  output logic                         out_run_end,
  output logic                         out_status,
  // configuration
  input  wire                          cfg_we,
  input  wire logic [SEL_BITS-1:0]     cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_SELECT + 1);

  ksel_state_t                   state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt, count_ins;
  logic [SEL_BITS-1:0]           select_r;
  logic [SEL_BITS-1:0]           remain_r, remain_nxt;
  logic                          out_valid_r;
  logic signed [VALUE_BITS-1:0]  out_value_r;
  logic                          out_run_end_r, out_status_r;
  logic                          in_fire, out_free, emit;
  ksel_cell_ctl_t                ctl;

  logic signed [VALUE_BITS-1:0]  cell_value [MAX_SELECT];
  logic                          cell_le    [MAX_SELECT];

  assign in_ready = (state_r == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = out_free && ((state_r == ST_DRAIN) || (state_r == ST_ERR));

  assign ctl.insert = in_fire;
  assign ctl.shift  = out_free && (state_r == ST_DRAIN);

  // Sorted chain, head at cell 0
  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] prev_v, next_v;
    logic                         prev_le_w;
    if (i == 0) begin : g_head
      assign prev_v    = in_sample_value;
      assign prev_le_w = 1'b1;
    end else begin : g_body
      assign prev_v    = cell_value[i-1];
      assign prev_le_w = cell_le[i-1];
    end
    if (i == MAX_SELECT - 1) begin : g_tail
      assign next_v = cell_value[i];
    end else begin : g_mid
      assign next_v = cell_value[i+1];
    end
    ksel_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (count_r > CW'(i)),
      .new_value (in_sample_value),
      .prev_value(prev_v),
      .prev_le   (prev_le_w),
      .next_value(next_v),
      .value     (cell_value[i]),
      .le        (cell_le[i])
    );
  end

  // Element count after this insert, saturating
  assign count_ins = (count_r == CW'(MAX_SELECT)) ? count_r : count_r + CW'(1);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          count_nxt = count_ins;
          if (in_set_end) begin
            if (select_r == '0) begin
              count_nxt = '0;
            end else if (select_r > SEL_BITS'(count_ins)) begin
              state_nxt = ST_ERR;
            end else begin
              state_nxt  = ST_DRAIN;
              remain_nxt = select_r;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          remain_nxt = remain_r - SEL_BITS'(1);
          if (remain_r == SEL_BITS'(1)) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      remain_r <= '0;
      select_r <= SEL_BITS'(1);
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      if (cfg_we) begin
        select_r <= cfg_wdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state_r == ST_ERR) begin
        out_value_r   <= '0;
        out_run_end_r <= 1'b1;
        out_status_r  <= STATUS_TOO_FEW;
      end else begin
        out_value_r   <= cell_value[0];
        out_run_end_r <= (remain_r == SEL_BITS'(1));
        out_status_r  <= STATUS_OK;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_value = out_value_r;
  assign out_run_end      = out_run_end_r;
  assign out_status       = out_status_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SELECT))
    else $error("element count beyond chain length");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == STATUS_TOO_FEW) |-> out_run_end_r)
    else $error("error result not marked as last");

  a_drain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (remain_r != '0))
    else $error("draining with nothing left");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERR) && out_free |=> (state_r == ST_LOAD) && (count_r == '0))
    else $error("error result not followed by a cleared set");

endmodule
`default_nettype wire

### tb/tb_k_smallest_selector_core.sv
// Testbench for k_smallest_selector_core: random data sets against a sorted-store predictor.
`timescale 1ns / 100ps
module tb_k_smallest_selector_core;
  import ksel_pkg::*;

  localparam int MAX_SEL     = 64;
  localparam int SET_ITEMS   = 420;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 8_000_000;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // One expected result
  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               status;
  } pick_t;

  // Scoreboard: keeps the running sorted set and the picks it implies
  class smallest_pick_board;
    logic signed [31:0] sorted_kept[$];
    logic [SEL_BITS-1:0] pick_count;
    pick_t pending_picks[$];
    int fail_count;

    function new();
      pick_count = 7'd1;
      fail_count = 0;
    endfunction

    function void set_pick_count(logic [SEL_BITS-1:0] k);
      pick_count = k;
    endfunction

    function int pending();
      return pending_picks.size();
    endfunction

    // Insert one accepted element; on set end, queue the picks and clear
    function void take_sample(logic signed [31:0] v, logic last);
      int pos;
      pick_t p;
      pos = 0;
      // equal values keep arrival order
      while (pos < sorted_kept.size() && sorted_kept[pos] <= v) pos++;
      if (pos < MAX_SEL) begin
        sorted_kept.insert(pos, v);
        if (sorted_kept.size() > MAX_SEL) void'(sorted_kept.pop_back());
      end
      if (!last) return;
      if (pick_count == 0) begin
        // nothing to emit
      end else if (int'(pick_count) > sorted_kept.size()) begin
        p.value  = '0;
        p.last   = 1'b1;
        p.status = STATUS_TOO_FEW;
        pending_picks.push_back(p);
      end else begin
        for (int n = 0; n < int'(pick_count); n++) begin
          p.value  = sorted_kept[n];
          p.last   = (n + 1 == int'(pick_count));
          p.status = STATUS_OK;
          pending_picks.push_back(p);
        end
      end
      sorted_kept.delete();
    endfunction

    // Compare one accepted result with the oldest expectation
    function void match_pick(logic signed [31:0] v, logic last, logic status);
      pick_t e;
      if (pending_picks.size() == 0) begin
        $error("unexpected result: picked_value %0d run_end %0d status %0d", v, last, status);
        fail_count++;
        return;
      end
      e = pending_picks.pop_front();
      if (v !== e.value) begin
        $error("picked_value: expected %0d, got %0d", e.value, v);
        fail_count++;
      end
      if (last !== e.last) begin
        $error("run_end: expected %0d, got %0d", e.last, last);
        fail_count++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_sample_value = '0;
  logic in_set_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_picked_value;
  logic out_run_end;
  logic out_status;
  logic cfg_we = 1'b0;
  logic [SEL_BITS-1:0] cfg_wdata = '0;

  smallest_pick_board board = new();
  bit quiet = 1'b0;
  int items_sent = 0;
  int cycles = 0;
  int ready_hold = 0;

  k_smallest_selector_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_picked_value (out_picked_value),
    .out_run_end      (out_run_end),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element value: full range, a narrow band for duplicates, or an extreme
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 85) return $signed(32'($urandom_range(0, 8))) - 32'sd4;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Receiver: random stretches of ready high and stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= gap_len();
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.match_pick(out_picked_value, out_run_end, out_status);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[k_smallest_selector_core] ERROR");
      $finish;
    end
  end

  // Present one element and wait for its transaction
  task automatic send_item(input logic signed [31:0] v, input logic last);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_set_end      <= last;
    do @(posedge clk); while (!in_ready);
    board.take_sample(v, last);
    items_sent++;
  endtask

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) send_item(pick_value(), i == size - 1);
  endtask

  // Sender holds off until every expected result is in, then lets the block settle
  task automatic hold_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pick_count(input logic [SEL_BITS-1:0] k);
    hold_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_pick_count(k);
  endtask

  initial begin
    logic [SEL_BITS-1:0] k;
    int nsets;
    int size;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset count of one, extremes of the value range
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    send_item(-32'sd1, 1'b1);

    // Duplicates kept, earlier first
    write_pick_count(7'd3);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b1);

    // Zero count emits nothing
    write_pick_count(7'd0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd8, 1'b1);

    // Count above elements loaded
    write_pick_count(7'd4);
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b1);

    // Count above the store size
    write_pick_count(7'd127);
    send_item(32'sd3, 1'b1);

    // Every value extreme in one set
    write_pick_count(7'd4);
    send_item(32'sh5555_5555, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sh2aaa_aaaa, 1'b1);

    // Random phases: new count, then a few sets
    while (items_sent < SET_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       k = 7'd0;
        1:       k = 7'(MAX_SEL);
        2:       k = 7'd127;
        3:       k = 7'($urandom_range(MAX_SEL + 1, 126));
        4, 5:    k = 7'($urandom_range(1, 4));
        default: k = 7'($urandom_range(1, 16));
      endcase
      write_pick_count(k);
      quiet = ($urandom_range(0, 3) == 0);
      nsets = (k == 7'(MAX_SEL)) ? 1 : $urandom_range(1, 4);
      for (int s = 0; s < nsets && items_sent < SET_ITEMS; s++) begin
        if (k == 7'(MAX_SEL))
          size = ($urandom_range(0, 3) != 0) ? $urandom_range(MAX_SEL, MAX_SEL + 16)
                                             : $urandom_range(20, MAX_SEL - 1);
        else if (k == 0 || int'(k) > MAX_SEL)
          size = $urandom_range(1, 6);
        else if ($urandom_range(0, 3) != 0)
          size = $urandom_range(int'(k), int'(k) + 8);
        else
          size = $urandom_range(1, 12);
        send_set(size);
        if ($urandom_range(0, 9) == 0) hold_for_drain();
      end
    end

    // Drain and watch for stray results
    quiet = 1'b0;
    hold_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("[k_smallest_selector_core] OK");
    end else begin
      $display("[k_smallest_selector_core] ERROR");
    end
    $finish;
  end

endmodule
